@@ design/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ design/tpq_pkg.sv @@
// package: sizes, codes and types of the timestamp priority queue
`default_nettype none
package tpq_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int TIME_BITS   = 32;
	localparam int TAG_BITS    = 16;
	localparam int OCC_BITS    = $clog2(QUEUE_DEPTH + 1);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                 valid;
		logic [TIME_BITS-1:0] ev_time;
		logic [TAG_BITS-1:0]  ev_tag;
	} slot_t;

	typedef struct packed {
		logic                 ins;
		logic                 rem;
		logic [TIME_BITS-1:0] ev_time;
		logic [TAG_BITS-1:0]  ev_tag;
	} ctrl_t;
endpackage
`default_nettype wire

@@ design/tpq_cell.sv @@
// one slot of the shift-register queue
`default_nettype none
module tpq_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tpq_pkg::ctrl_t ctrl,
	input  wire tpq_pkg::slot_t left_slot,
	input  wire logic          left_disp,
	input  wire tpq_pkg::slot_t right_slot,
	output tpq_pkg::slot_t     slot,
	output logic               disp
);
	import tpq_pkg::*;

	logic                 valid_q;
	logic [TIME_BITS-1:0] time_q;
	logic [TAG_BITS-1:0]  tag_q;

	// this entry moves one place back on insert
	assign disp = valid_q && (time_q >= ctrl.ev_time);

	assign slot.valid   = valid_q;
	assign slot.ev_time = time_q;
	assign slot.ev_tag  = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			valid_q <= valid_q || left_slot.valid;
		end else if (ctrl.rem) begin
			valid_q <= right_slot.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (disp || !valid_q) begin
				if (left_disp) begin
					time_q <= left_slot.ev_time;
					tag_q  <= left_slot.ev_tag;
				end else begin
					time_q <= ctrl.ev_time;
					tag_q  <= ctrl.ev_tag;
				end
			end
		end else if (ctrl.rem) begin
			time_q <= right_slot.ev_time;
			tag_q  <= right_slot.ev_tag;
		end
	end
endmodule
`default_nettype wire

@@ design/timestamp_priority_queue.sv @@
// top level: timestamp-ordered event queue built from a row of slot cells
//
//   channel   direction  handshake            payload
//   request   in         in_valid / in_ready  cmd, event_time, event_tag
//   result    out        out_valid / out_ready status, popped_time, popped_tag, occupancy
//
// one request per cycle while the result is not stalled: every cell compares and shifts in the accept cycle,
// the result appears in the output register on the next cycle
// in_ready is high while the output register is empty or being drained
// reset empties the queue at once; slot contents are not cleared
`default_nettype none
module timestamp_priority_queue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         cmd,
	input  wire logic [tpq_pkg::TIME_BITS-1:0] event_time,
	input  wire logic [tpq_pkg::TAG_BITS-1:0]  event_tag,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        status,
	output logic [tpq_pkg::TIME_BITS-1:0]      popped_time,
	output logic [tpq_pkg::TAG_BITS-1:0]       popped_tag,
	output logic [tpq_pkg::OCC_BITS-1:0]       occupancy
);
	import tpq_pkg::*;

	logic                 accept;
	logic                 full;
	logic                 empty;
	ctrl_t                ctrl;
	slot_t                slots [QUEUE_DEPTH];
	logic                 disps [QUEUE_DEPTH];
	logic [OCC_BITS-1:0]  occ_q;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [TIME_BITS-1:0] ptime_q;
	logic [TAG_BITS-1:0]  ptag_q;
	logic [OCC_BITS-1:0]  occ_out_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (occ_q == OCC_BITS'(QUEUE_DEPTH));
	assign empty    = (occ_q == '0);

	assign ctrl.ins     = accept && (cmd == CMD_INSERT) && !full;
	assign ctrl.rem     = accept && (cmd == CMD_REMOVE) && !empty;
	assign ctrl.ev_time = event_time;
	assign ctrl.ev_tag  = event_tag;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		slot_t left_slot;
		logic  left_disp;
		slot_t right_slot;

		if (i == 0) begin : g_head
			assign left_slot.valid   = 1'b1;
			assign left_slot.ev_time = event_time;
			assign left_slot.ev_tag  = event_tag;
			assign left_disp         = 1'b0;
		end else begin : g_body
			assign left_slot = slots[i-1];
			assign left_disp = disps[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_slot.valid   = 1'b0;
			assign right_slot.ev_time = slots[i].ev_time;
			assign right_slot.ev_tag  = slots[i].ev_tag;
		end else begin : g_mid
			assign right_slot = slots[i+1];
		end

		tpq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.left_slot  (left_slot),
			.left_disp  (left_disp),
			.right_slot (right_slot),
			.slot       (slots[i]),
			.disp       (disps[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.ins) begin
				occ_q <= occ_q + OCC_BITS'(1);
			end else if (ctrl.rem) begin
				occ_q <= occ_q - OCC_BITS'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			priority if (ctrl.rem) begin
				status_q  <= ST_DONE;
				ptime_q   <= slots[0].ev_time;
				ptag_q    <= slots[0].ev_tag;
				occ_out_q <= occ_q - OCC_BITS'(1);
			end else if (ctrl.ins) begin
				status_q  <= ST_DONE;
				ptime_q   <= '0;
				ptag_q    <= '0;
				occ_out_q <= occ_q + OCC_BITS'(1);
			end else begin
				status_q  <= (cmd == CMD_REMOVE) ? ST_EMPTY : ST_FULL;
				ptime_q   <= '0;
				ptag_q    <= '0;
				occ_out_q <= occ_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign popped_time = ptime_q;
	assign popped_tag  = ptag_q;
	assign occupancy   = occ_out_q;
endmodule
`default_nettype wire

@@ design/tpq_checker.sv @@
// port-level checker for the timestamp priority queue, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module tpq_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [1:0]                   status,
	input wire logic [tpq_pkg::TIME_BITS-1:0] popped_time,
	input wire logic [tpq_pkg::TAG_BITS-1:0]  popped_tag,
	input wire logic [tpq_pkg::OCC_BITS-1:0]  occupancy
);
	import tpq_pkg::*;

	// a stalled result holds its status, popped time and occupancy
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(popped_time) && $stable(occupancy))
	// every accepted request gives a result next cycle
	`ASSERT_NEXT(a_req_result, clk, arst_n, in_valid && in_ready, out_valid)
	// empty report leaves nothing stored and pops nothing
	`ASSERT_IMPLY(a_empty, clk, arst_n, out_valid && status == ST_EMPTY, occupancy == '0 && popped_time == '0 && popped_tag == '0)
	// full report only at full depth
	`ASSERT_IMPLY(a_full, clk, arst_n, out_valid && status == ST_FULL, occupancy == OCC_BITS'(QUEUE_DEPTH))
	// occupancy never exceeds depth
	`ASSERT_IMPLY(a_occ, clk, arst_n, out_valid, occupancy <= OCC_BITS'(QUEUE_DEPTH))
endmodule

bind timestamp_priority_queue tpq_checker u_tpq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.popped_time (popped_time),
	.popped_tag  (popped_tag),
	.occupancy   (occupancy)
);
`default_nettype wire
